// ===== rtl/dwdt_pkg.sv =====
// ----------------------------------------------------------------------------
// dwdt_pkg
// Shared types and constants for the dual watchdog timer register block.
// ----------------------------------------------------------------------------
package dwdt_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } dwdt_action_t;

  // Register word indexes; 8..15 are out of range.
  localparam logic [3:0] REG_CHIP_COUNT       = 4'd0;
  localparam logic [3:0] REG_CHIP_RESET_LIMIT = 4'd1;
  localparam logic [3:0] REG_CHIP_IRQ_LIMIT   = 4'd2;
  localparam logic [3:0] REG_CHIP_CTRL        = 4'd3;
  localparam logic [3:0] REG_SYS_COUNT        = 4'd4;
  localparam logic [3:0] REG_SYS_RESET_LIMIT  = 4'd5;
  localparam logic [3:0] REG_SPARE_WORD       = 4'd6;
  localparam logic [3:0] REG_SYS_CTRL         = 4'd7;

  // Control word bit positions.
  localparam int unsigned CTL_EN_IRQ   = 0;
  localparam int unsigned CTL_PENDING  = 1;
  localparam int unsigned CTL_EN_RESET = 2;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
  } dwdt_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        reset_fired;
  } dwdt_out_t;

endpackage

// ===== rtl/dual_watchdog_timer_regs_core.sv =====
// ----------------------------------------------------------------------------
// dual_watchdog_timer_regs_core
// Dual watchdog timer register block: input register, update logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries transactions:
//   tick, register read, register write or none. Response channel (rsp_valid /
//   rsp_stall / rsp) returns exactly one transaction per request, in order,
//   with read data, the interrupt line level and a watchdog-reset flag.
//   Path: a request passes the input register, then the result register,
//   before its response is valid; rsp_stall can hold it in either.
//   Throughput: one transaction per cycle while rsp_stall does not hold the
//   response register; the register file is read and updated between the
//   two registers, so each request sees the state left by the one before.
//   Stall: while the response register is held by rsp_stall, the input
//   register keeps its transaction and req_stall rises only once it is full.
//   Reset (rst, synchronous): clears both counters, limits, control words,
//   the interrupt line and both valid flags.
// ----------------------------------------------------------------------------
module dual_watchdog_timer_regs_core import dwdt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  dwdt_in_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output dwdt_out_t rsp
);

  logic      in_valid;   // input register holds a transaction
  dwdt_in_t  in_item;
  logic      advance;    // process input register into result register
  dwdt_out_t result;

  // Result register can take a new value if empty or being drained.
  assign advance   = in_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!req_stall) begin
      in_valid <= req_valid;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_item <= req;
    end
  end

  dwdt_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

endmodule

// ===== rtl/dwdt_regs.sv =====
// ----------------------------------------------------------------------------
// dwdt_regs
// Watchdog register file with tick, read, write and limit-check logic.
// ----------------------------------------------------------------------------
module dwdt_regs import dwdt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  dwdt_in_t  item,
  output dwdt_out_t result
);

  logic [31:0] chip_count, chip_reset_limit, chip_irq_limit, chip_ctrl;
  logic [31:0] sys_count, sys_reset_limit, spare_word, sys_ctrl;
  logic        irq_line;

  // values after the operation, before the limit check
  logic [31:0] p_chip_count, p_chip_reset_limit, p_chip_irq_limit, p_chip_ctrl;
  logic [31:0] p_sys_count, p_sys_reset_limit, p_spare_word, p_sys_ctrl;
  logic        p_irq;
  logic        do_check;
  logic [31:0] rdata;
  logic        chip_rst_hit, sys_rst_hit, fire_rst, set_irq;

  logic [31:0] chip_count_next, chip_reset_limit_next, chip_irq_limit_next;
  logic [31:0] chip_ctrl_next, sys_count_next, sys_reset_limit_next;
  logic [31:0] spare_word_next, sys_ctrl_next;
  logic        irq_line_next;

  always_comb begin
    p_chip_count       = chip_count;
    p_chip_reset_limit = chip_reset_limit;
    p_chip_irq_limit   = chip_irq_limit;
    p_chip_ctrl        = chip_ctrl;
    p_sys_count        = sys_count;
    p_sys_reset_limit  = sys_reset_limit;
    p_spare_word       = spare_word;
    p_sys_ctrl         = sys_ctrl;
    p_irq              = irq_line;
    do_check           = 1'b0;
    rdata              = '0;
    case (item.action)
      ACT_TICK: begin
        p_chip_count = chip_count + 32'd1;
        p_sys_count  = sys_count + 32'd1;
        do_check     = 1'b1;
      end
      ACT_READ: begin
        case (item.reg_index)
          REG_CHIP_COUNT:       rdata = chip_count;
          REG_CHIP_RESET_LIMIT: rdata = chip_reset_limit;
          REG_CHIP_IRQ_LIMIT:   rdata = chip_irq_limit;
          REG_CHIP_CTRL:        rdata = chip_ctrl;
          REG_SYS_COUNT:        rdata = sys_count;
          REG_SYS_RESET_LIMIT:  rdata = sys_reset_limit;
          REG_SPARE_WORD:       rdata = spare_word;
          REG_SYS_CTRL:         rdata = sys_ctrl;
          default:              rdata = '0;
        endcase
      end
      ACT_WRITE: begin
        do_check = 1'b1;
        case (item.reg_index)
          REG_CHIP_COUNT:       p_chip_count = item.write_data;
          REG_CHIP_RESET_LIMIT: p_chip_reset_limit = item.write_data;
          REG_CHIP_IRQ_LIMIT:   p_chip_irq_limit = item.write_data;
          REG_CHIP_CTRL: begin
            if (item.write_data[CTL_PENDING]) p_irq = 1'b0;
            p_chip_ctrl = item.write_data;
            p_chip_ctrl[CTL_PENDING] = 1'b0;
          end
          REG_SYS_COUNT:        p_sys_count = item.write_data;
          REG_SYS_RESET_LIMIT:  p_sys_reset_limit = item.write_data;
          REG_SPARE_WORD:       p_spare_word = item.write_data;
          REG_SYS_CTRL:         p_sys_ctrl = item.write_data;
          default:              do_check = 1'b0;  // out of range: ignored
        endcase
      end
      default: ;
    endcase
  end

  assign chip_rst_hit = p_chip_ctrl[CTL_EN_RESET] && (p_chip_count >= p_chip_reset_limit);
  assign sys_rst_hit  = p_sys_ctrl[CTL_EN_RESET] && (p_sys_count >= p_sys_reset_limit);
  assign fire_rst     = do_check && (chip_rst_hit || sys_rst_hit);
  assign set_irq      = do_check && !fire_rst && p_chip_ctrl[CTL_EN_IRQ]
                        && (p_chip_count >= p_chip_irq_limit) && !p_chip_ctrl[CTL_PENDING];

  always_comb begin
    chip_count_next       = p_chip_count;
    chip_reset_limit_next = p_chip_reset_limit;
    chip_irq_limit_next   = p_chip_irq_limit;
    chip_ctrl_next        = p_chip_ctrl;
    sys_count_next        = p_sys_count;
    sys_reset_limit_next  = p_sys_reset_limit;
    spare_word_next       = p_spare_word;
    sys_ctrl_next         = p_sys_ctrl;
    irq_line_next         = p_irq;
    if (fire_rst) begin
      // watchdog reset clears the registers but not the interrupt line
      chip_count_next       = '0;
      chip_reset_limit_next = '0;
      chip_irq_limit_next   = '0;
      chip_ctrl_next        = '0;
      sys_count_next        = '0;
      sys_reset_limit_next  = '0;
      spare_word_next       = '0;
      sys_ctrl_next         = '0;
    end else if (set_irq) begin
      chip_ctrl_next[CTL_PENDING] = 1'b1;
      irq_line_next               = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_count       <= '0;
      chip_reset_limit <= '0;
      chip_irq_limit   <= '0;
      chip_ctrl        <= '0;
      sys_count        <= '0;
      sys_reset_limit  <= '0;
      spare_word       <= '0;
      sys_ctrl         <= '0;
      irq_line         <= 1'b0;
    end else if (fire) begin
      chip_count       <= chip_count_next;
      chip_reset_limit <= chip_reset_limit_next;
      chip_irq_limit   <= chip_irq_limit_next;
      chip_ctrl        <= chip_ctrl_next;
      sys_count        <= sys_count_next;
      sys_reset_limit  <= sys_reset_limit_next;
      spare_word       <= spare_word_next;
      sys_ctrl         <= sys_ctrl_next;
      irq_line         <= irq_line_next;
    end
  end

  assign result.read_data   = rdata;
  assign result.irq_level   = irq_line_next;
  assign result.reset_fired = fire_rst;

endmodule

// ===== rtl/dwdt_checker.sv =====
// ----------------------------------------------------------------------------
// dwdt_checker
// Port-level checks for the dual watchdog timer register block.
// ----------------------------------------------------------------------------
module dwdt_checker import dwdt_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input dwdt_in_t  req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input dwdt_out_t rsp
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // stalled request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("request changed while stalled");

  // request side only stalls when the response register is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without downstream backpressure");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("pipeline not empty after reset");

  // an accepted request into an empty pipe produces a response after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && !rsp_valid |=> 1'b1 ##1 rsp_valid)
    else $error("response missing after request");

endmodule

bind dual_watchdog_timer_regs_core dwdt_checker u_dwdt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
